// ----- hw/rtl/tlv_integer_and_header_encoder_top_macros.svh -----
// Assertion macros used by the encoder datapath.
// Depends on nothing; files that assert include it by name.
`ifndef TLV_INTEGER_AND_HEADER_ENCODER_TOP_MACROS_SVH
`define TLV_INTEGER_AND_HEADER_ENCODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLVENC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlvenc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TLVENC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvenc assertion failed");

`endif

// ----- hw/rtl/tlvenc_pkg.sv -----
// Types and constants of the TLV integer and header encoder.
// Used by every module of the block; depends on nothing.
package tlvenc_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_INTEGER  = 2'd0,
        CMD_STRING   = 2'd1,
        CMD_BLOB     = 2'd2,
        CMD_SEQUENCE = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_INTEGER_TAG  = 2'd0;
    localparam logic [1:0] REG_STRING_TAG   = 2'd1;
    localparam logic [1:0] REG_BLOB_TAG     = 2'd2;
    localparam logic [1:0] REG_SEQUENCE_TAG = 2'd3;

    localparam logic [7:0] RST_INTEGER_TAG  = 8'd2;
    localparam logic [7:0] RST_STRING_TAG   = 8'd22;
    localparam logic [7:0] RST_BLOB_TAG     = 8'd4;
    localparam logic [7:0] RST_SEQUENCE_TAG = 8'd48;

    localparam logic [31:0] ONE_BYTE_MAX   = 32'h0000_007f;
    localparam logic [31:0] TWO_BYTE_MAX   = 32'h0000_ffff;
    localparam logic [31:0] THREE_BYTE_MAX = 32'h00ff_ffff;
    localparam logic [30:0] SHORT_LEN_MAX  = 31'd127;
    localparam logic [7:0]  NEG_TAG_BIT    = 8'h40;
    localparam logic [7:0]  LONG_FORM_BIT  = 8'h80;

    typedef struct packed {
        logic [7:0] integer_tag;
        logic [7:0] string_tag;
        logic [7:0] blob_tag;
        logic [7:0] sequence_tag;
    } t_tags;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

// ----- hw/rtl/tlvenc_stream_if.sv -----
// Valid/ready channel interfaces for command input and byte output.
// Depends on nothing outside this file.
interface tlvenc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] int_value;
    logic [30:0]        body_length;

    modport source (output valid, cmd, int_value, body_length, input ready);
    modport sink (input valid, cmd, int_value, body_length, output ready);
endinterface

interface tlvenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- hw/rtl/tlvenc_regs.sv -----
// APB configuration registers holding the four tag bytes.
// Depends on tlvenc_pkg.
module tlvenc_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [tlvenc_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [tlvenc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [tlvenc_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                                 o_pready,
    output tlvenc_pkg::t_tags                    o_tags
);
    import tlvenc_pkg::*;

    t_tags      r_tags;
    t_tags      n_tags;
    logic [1:0] reg_idx;
    logic [7:0] rd_byte;

    assign reg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;
    assign o_tags   = r_tags;

    always_comb begin
        n_tags = r_tags;
        if (i_psel && i_penable && i_pwrite && o_pready) begin
            case (reg_idx)
                REG_INTEGER_TAG:  n_tags.integer_tag  = i_pwdata[7:0];
                REG_STRING_TAG:   n_tags.string_tag   = i_pwdata[7:0];
                REG_BLOB_TAG:     n_tags.blob_tag     = i_pwdata[7:0];
                REG_SEQUENCE_TAG: n_tags.sequence_tag = i_pwdata[7:0];
                default:          n_tags = r_tags;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_INTEGER_TAG:  rd_byte = r_tags.integer_tag;
            REG_STRING_TAG:   rd_byte = r_tags.string_tag;
            REG_BLOB_TAG:     rd_byte = r_tags.blob_tag;
            REG_SEQUENCE_TAG: rd_byte = r_tags.sequence_tag;
            default:          rd_byte = 8'h00;
        endcase
        o_prdata = {{(APB_DATA_W-8){1'b0}}, rd_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags.integer_tag  <= RST_INTEGER_TAG;
            r_tags.string_tag   <= RST_STRING_TAG;
            r_tags.blob_tag     <= RST_BLOB_TAG;
            r_tags.sequence_tag <= RST_SEQUENCE_TAG;
        end else begin
            r_tags <= n_tags;
        end
    end

endmodule

// ----- hw/rtl/tlvenc_ctrl.sv -----
// Controller state machine: takes a command, then steps the byte beats out.
// Depends on tlvenc_pkg.
module tlvenc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  tlvenc_pkg::t_dp_stat  i_stat,
    output tlvenc_pkg::t_dp_cmd   o_cmd
);
    import tlvenc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   send;

    assign send        = (r_state == ST_SEND);
    assign o_out_valid = send;
    assign o_cmd.shift = send && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) || (o_cmd.shift && i_stat.last);
    assign o_cmd.load  = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (o_cmd.load) begin
                    n_state = ST_SEND;
                end else if (o_cmd.shift && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/tlvenc_dp.sv -----
// Datapath: sizes the field, builds the byte run and shifts it out.
// Depends on tlvenc_pkg and the assertion macro header.
`include "tlv_integer_and_header_encoder_top_macros.svh"

module tlvenc_dp #(
    parameter int unsigned MAX_FIELD_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlvenc_pkg::t_dp_cmd   i_cmd,
    output tlvenc_pkg::t_dp_stat  o_stat,
    input  tlvenc_pkg::t_tags     i_tags,
    input  logic [1:0]            i_op,
    input  logic signed [31:0]    i_int_value,
    input  logic [30:0]           i_body_length,
    output logic [7:0]            o_out_byte,
    output logic                  o_last
);
    import tlvenc_pkg::*;

    logic [47:0] r_shift;
    logic [47:0] n_shift;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;

    logic        is_int;
    logic        neg;
    logic [31:0] mag;
    logic [2:0]  raw_size;
    logic [2:0]  size;
    logic [7:0]  tag;
    logic [7:0]  hdr;
    logic [31:0] aligned;
    logic [2:0]  load_cnt;

    always_comb begin
        is_int = (i_op == CMD_INTEGER);
        neg    = is_int && i_int_value[31];
        if (!is_int) begin
            mag = {1'b0, i_body_length};
        end else if (neg) begin
            mag = 32'(-i_int_value);
        end else begin
            mag = 32'(i_int_value);
        end

        if (mag <= ONE_BYTE_MAX) begin
            raw_size = 3'd1;
        end else if (mag <= TWO_BYTE_MAX) begin
            raw_size = 3'd2;
        end else if (mag <= THREE_BYTE_MAX) begin
            raw_size = 3'd3;
        end else begin
            raw_size = 3'd4;
        end
        size = (raw_size > 3'(MAX_FIELD_BYTES)) ? 3'(MAX_FIELD_BYTES) : raw_size;

        case (size)
            3'd1:    aligned = {mag[7:0], 24'h000000};
            3'd2:    aligned = {mag[15:0], 16'h0000};
            3'd3:    aligned = {mag[23:0], 8'h00};
            default: aligned = mag;
        endcase

        case (i_op)
            CMD_INTEGER:  tag = neg ? (i_tags.integer_tag | NEG_TAG_BIT) : i_tags.integer_tag;
            CMD_STRING:   tag = i_tags.string_tag;
            CMD_BLOB:     tag = i_tags.blob_tag;
            CMD_SEQUENCE: tag = i_tags.sequence_tag;
            default:      tag = i_tags.sequence_tag;
        endcase

        if (is_int) begin
            hdr      = {5'b00000, size};
            load_cnt = 3'd2 + size;
        end else if (i_body_length <= SHORT_LEN_MAX) begin
            hdr      = {1'b0, i_body_length[6:0]};
            load_cnt = 3'd2;
        end else begin
            hdr      = LONG_FORM_BIT | {5'b00000, size};
            load_cnt = 3'd2 + size;
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        if (i_cmd.load) begin
            n_shift = {tag, hdr, aligned};
            n_cnt   = load_cnt;
        end else if (i_cmd.shift) begin
            n_shift = {r_shift[39:0], 8'h00};
            n_cnt   = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign o_stat.last = (r_cnt == 3'd1);
    assign o_last      = o_stat.last;
    assign o_out_byte  = r_shift[47:40];

    `TLVENC_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, i_cmd.load, (r_cnt >= 3'd2) && (r_cnt <= 3'd6))
    `TLVENC_ASSERT_NEXT(a_shift_count, i_clk, i_rst_n, i_cmd.shift && !i_cmd.load, r_cnt == $past(r_cnt) - 3'd1)
    `TLVENC_ASSERT_SAME(a_shift_live, i_clk, i_rst_n, i_cmd.shift, r_cnt != 3'd0)

endmodule

// ----- hw/rtl/tlv_integer_and_header_encoder_top.sv -----
// The first byte of a command is valid in the cycle after it is accepted.
// A command yields 2 to 6 beats, one per cycle while the sink is ready;
// the next command is taken in the cycle of the current run's last beat, so
// runs from the byte shift register can follow one another without a gap.
// Reset (synchronous, active low) empties the run and restores the default tags.
module tlv_integer_and_header_encoder_top #(
    parameter int unsigned MAX_FIELD_BYTES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    tlvenc_in_if.sink                            i_in,
    tlvenc_out_if.source                         o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tlvenc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tlvenc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tlvenc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);
    import tlvenc_pkg::*;

    t_tags    tags;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tlvenc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_tags    (tags)
    );

    tlvenc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tlvenc_dp #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_tags        (tags),
        .i_op          (i_in.cmd),
        .i_int_value   (i_in.int_value),
        .i_body_length (i_in.body_length),
        .o_out_byte    (o_out.out_byte),
        .o_last        (o_out.last)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the TLV integer and header encoder top level.
// Depends on tlvenc_pkg and the stream interfaces; predicts every output beat
// and compares it with the encoder's byte stream under varied idling.
`timescale 1ns / 1ps

module tb;
    import tlvenc_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle_mix;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_enc_beat;

    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_TICKS = 4;

    logic i_clk;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tlvenc_in_if  in_ch ();
    tlvenc_out_if out_ch ();

    tlv_integer_and_header_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_enc_beat  expected_bytes[$];
    logic [7:0] tag_copy[4];
    t_idle_mix  idle_mix;
    int         error_count;
    int         cmds_sent;
    int         beats_checked;
    int         hold_requests;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int byte_count(input logic [31:0] mag);
        if (mag <= ONE_BYTE_MAX) begin
            return 1;
        end else if (mag <= TWO_BYTE_MAX) begin
            return 2;
        end else if (mag <= THREE_BYTE_MAX) begin
            return 3;
        end
        return 4;
    endfunction

    function automatic void predict_encoding(input t_cmd c, input logic [31:0] value,
                                             input logic [30:0] len);
        logic [7:0]  run[$];
        logic [31:0] mag;
        logic [31:0] len32;
        logic        neg;
        int          n;
        t_enc_beat   b;
        if (c == CMD_INTEGER) begin
            neg = value[31];
            mag = neg ? (~value + 32'd1) : value;
            n = byte_count(mag);
            run.push_back(neg ? (tag_copy[REG_INTEGER_TAG] | NEG_TAG_BIT)
                              : tag_copy[REG_INTEGER_TAG]);
            run.push_back(8'(n));
            for (int i = n; i > 0; i--) begin
                run.push_back(mag[(i - 1) * 8 +: 8]);
            end
        end else begin
            case (c)
                CMD_STRING: run.push_back(tag_copy[REG_STRING_TAG]);
                CMD_BLOB:   run.push_back(tag_copy[REG_BLOB_TAG]);
                default:    run.push_back(tag_copy[REG_SEQUENCE_TAG]);
            endcase
            if (len > SHORT_LEN_MAX) begin
                len32 = {1'b0, len};
                n = byte_count(len32);
                run.push_back(LONG_FORM_BIT | 8'(n));
                for (int i = n; i > 0; i--) begin
                    run.push_back(len32[(i - 1) * 8 +: 8]);
                end
            end else begin
                run.push_back(len[7:0]);
            end
        end
        foreach (run[k]) begin
            b.data = run[k];
            b.last = (k == run.size() - 1);
            expected_bytes.push_back(b);
        end
    endfunction

    function automatic int src_gap_pct();
        case (idle_mix)
            IDLE_SRC:  return 54;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic int snk_stall_pct();
        case (idle_mix)
            IDLE_SNK:  return 54;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic logic [31:0] rand_int_value();
        logic [31:0] m;
        case ($urandom_range(0, 3))
            0: m = $urandom_range(0, 127);
            1: m = $urandom_range(128, 32'h0000_ffff);
            2: m = $urandom_range(32'h0001_0000, 32'h00ff_ffff);
            default: m = $urandom();
        endcase
        if ($urandom_range(0, 1) == 1) begin
            m = ~m + 32'd1;
        end
        return m;
    endfunction

    function automatic logic [30:0] rand_body_length();
        logic [31:0] m;
        case ($urandom_range(0, 4))
            0: m = $urandom_range(0, 127);
            1: m = $urandom_range(128, 255);
            2: m = $urandom_range(256, 32'h0000_ffff);
            3: m = $urandom_range(32'h0001_0000, 32'h00ff_ffff);
            default: m = $urandom();
        endcase
        return m[30:0];
    endfunction

    // Receiver: random stalls by idle mix, plus a long hold-off when one is requested.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct());
            end
        end
    end

    always @(posedge i_clk) begin
        t_enc_beat exp_beat;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_checked++;
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat, actual byte %02h last %0b",
                         $time, out_ch.out_byte, out_ch.last);
            end else begin
                exp_beat = expected_bytes.pop_front();
                if (out_ch.out_byte !== exp_beat.data) begin
                    error_count++;
                    $display("%0t: out_byte mismatch, expected %02h actual %02h",
                             $time, exp_beat.data, out_ch.out_byte);
                end
                if (out_ch.last !== exp_beat.last) begin
                    error_count++;
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, exp_beat.last, out_ch.last);
                end
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input logic [31:0] value,
                            input logic [30:0] len);
        while ($urandom_range(0, 99) < src_gap_pct()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= c;
        in_ch.int_value   <= value;
        in_ch.body_length <= len;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predict_encoding(c, value, len);
        cmds_sent++;
    endtask

    task automatic send_random(input int count);
        t_cmd c;
        repeat (count) begin
            c = t_cmd'($urandom_range(0, 3));
            if (c == CMD_INTEGER) begin
                send_cmd(c, rand_int_value(), 31'($urandom()));
            end else begin
                send_cmd(c, $urandom(), rand_body_length());
            end
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tag_copy[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic set_tags(input logic [7:0] int_tag, input logic [7:0] str_tag,
                            input logic [7:0] blob_tag, input logic [7:0] seq_tag);
        apb_write(REG_INTEGER_TAG, int_tag);
        apb_write(REG_STRING_TAG, str_tag);
        apb_write(REG_BLOB_TAG, blob_tag);
        apb_write(REG_SEQUENCE_TAG, seq_tag);
    endtask

    // Size boundaries, sign handling and the short/long length forms at reset tags.
    task automatic test_edge_values();
        idle_mix = IDLE_NONE;
        send_cmd(CMD_INTEGER, 32'd0, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'd1, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'd127, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'd128, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'hffff_ffff, 31'($urandom()));
        send_cmd(CMD_INTEGER, -32'sd127, 31'($urandom()));
        send_cmd(CMD_INTEGER, -32'sd128, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h0000_ffff, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h0001_0000, 31'($urandom()));
        send_cmd(CMD_INTEGER, -32'sh1_0000, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h00ff_ffff, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h0100_0000, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h7fff_ffff, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h8000_0001, 31'($urandom()));
        send_cmd(CMD_INTEGER, 32'h8000_0000, 31'($urandom()));
        send_cmd(CMD_STRING, $urandom(), 31'd0);
        send_cmd(CMD_STRING, $urandom(), 31'd127);
        send_cmd(CMD_BLOB, $urandom(), 31'd128);
        send_cmd(CMD_BLOB, $urandom(), 31'd255);
        send_cmd(CMD_SEQUENCE, $urandom(), 31'd256);
        send_cmd(CMD_SEQUENCE, $urandom(), 31'h0000_ffff);
        send_cmd(CMD_STRING, $urandom(), 31'h0001_0000);
        send_cmd(CMD_BLOB, $urandom(), 31'h00ff_ffff);
        send_cmd(CMD_SEQUENCE, $urandom(), 31'h0100_0000);
        send_cmd(CMD_STRING, $urandom(), 31'h7fff_ffff);
        wait_drained();
    endtask

    task automatic test_tag_extremes();
        set_tags(8'h00, 8'h00, 8'h00, 8'h00);
        idle_mix = IDLE_NONE;
        send_random(60);
        wait_drained();
        set_tags(8'hff, 8'hff, 8'hff, 8'hff);
        idle_mix = IDLE_SRC;
        send_random(60);
        wait_drained();
    endtask

    task automatic test_idle_mixes();
        set_tags(8'h40, 8'hbf, 8'h7f, 8'h80);
        idle_mix = IDLE_NONE;
        send_random(70);
        idle_mix = IDLE_SRC;
        send_random(70);
        wait_drained();
        set_tags(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        idle_mix = IDLE_SNK;
        send_random(70);
        idle_mix = IDLE_BOTH;
        send_random(70);
        wait_drained();
    endtask

    // The receiver holds off long enough for the encoder to back up its input.
    task automatic test_output_hold();
        idle_mix = IDLE_NONE;
        hold_requests++;
        send_random(40);
        wait_drained();
    endtask

    initial begin
        error_count   = 0;
        cmds_sent     = 0;
        beats_checked = 0;
        hold_requests = 0;
        idle_mix      = IDLE_NONE;
        tag_copy[REG_INTEGER_TAG]  = RST_INTEGER_TAG;
        tag_copy[REG_STRING_TAG]   = RST_STRING_TAG;
        tag_copy[REG_BLOB_TAG]     = RST_BLOB_TAG;
        tag_copy[REG_SEQUENCE_TAG] = RST_SEQUENCE_TAG;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_INTEGER;
        in_ch.int_value   <= '0;
        in_ch.body_length <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_tag_extremes();
        test_idle_mixes();
        test_output_hold();

        $display("Sent %0d commands and checked %0d output beats over tag extremes,",
                 cmds_sent, beats_checked);
        $display("four idle mixes and a long output hold-off.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
